// File: rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define TCCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked during reset
`define TCCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tccr_pkg.sv
package tccr_pkg;

  localparam int unsigned RGB_W = 24;
  localparam int unsigned DFLT_W = 9;

  // operation codes
  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_DEFAULT_FG = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_BG = 2'd1;
  localparam logic [1:0] CFG_BLINK_HIDE = 2'd2;

  // cell held between the lookup stage and the resolve stage
  typedef struct packed {
    logic             fg_true;
    logic [RGB_W-1:0] fg_rgb;
    logic             fg_black;
    logic             bg_true;
    logic [RGB_W-1:0] bg_rgb;
    logic             bg_black;
    logic             faint;
    logic             swap;
    logic             hide;
  } tccr_cell_t;

  // the sixteen named colors
  function automatic logic [RGB_W-1:0] tccr_named(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hcd0000;
      4'd2:    c = 24'h00cd00;
      4'd3:    c = 24'hcdcd00;
      4'd4:    c = 24'h0000ee;
      4'd5:    c = 24'hc000c0;
      4'd6:    c = 24'h00cdcd;
      4'd7:    c = 24'he5e5e5;
      4'd8:    c = 24'h7f7f7f;
      4'd9:    c = 24'hff0000;
      4'd10:   c = 24'h00ff00;
      4'd11:   c = 24'hffff00;
      4'd12:   c = 24'h5c5cff;
      4'd13:   c = 24'hff00ff;
      4'd14:   c = 24'h00ffff;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

  // entries past the 256-color set
  function automatic logic [RGB_W-1:0] tccr_special(input logic [2:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      3'd0:    c = 24'hcccccc;
      3'd2:    c = 24'h555555;
      3'd3:    c = 24'hcccccc;
      3'd5:    c = 24'hcccccc;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // one channel level of the color cube
  function automatic logic [7:0] tccr_cube_level(input logic [2:0] x);
    logic [7:0] v;
    case (x)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/tccr_ram.sv
module tccr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 262
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/tccr_init.sv
module tccr_init #(
  parameter int unsigned ENTRIES = 262
) (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        busy,
  output logic [$clog2(ENTRIES)-1:0]  waddr,
  output logic [tccr_pkg::RGB_W-1:0]  wdata
);

  import tccr_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]    cr_r, cr_nxt, cg_r, cg_nxt, cb_r, cb_nxt;
  logic [7:0]    gray_r, gray_nxt;
  logic          in_cube, in_gray;

  assign in_cube = (idx_r >= CW'(16)) && (idx_r < CW'(232));
  assign in_gray = (idx_r >= CW'(232)) && (idx_r < CW'(256));

  // sweep one entry per cycle, cube digits and gray level follow the index
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    cr_nxt   = cr_r;
    cg_nxt   = cg_r;
    cb_nxt   = cb_r;
    gray_nxt = gray_r;
    if (busy_r) begin
      idx_nxt = idx_r + CW'(1);
      if (idx_r == CW'(ENTRIES - 1)) begin
        busy_nxt = 1'b0;
      end
      if (in_cube) begin
        if (cb_r == 3'd5) begin
          cb_nxt = 3'd0;
          if (cg_r == 3'd5) begin
            cg_nxt = 3'd0;
            cr_nxt = cr_r + 3'd1;
          end else begin
            cg_nxt = cg_r + 3'd1;
          end
        end else begin
          cb_nxt = cb_r + 3'd1;
        end
      end
      if (in_gray) begin
        gray_nxt = gray_r + 8'd10;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      cr_r   <= '0;
      cg_r   <= '0;
      cb_r   <= '0;
      gray_r <= 8'd8;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      cr_r   <= cr_nxt;
      cg_r   <= cg_nxt;
      cb_r   <= cb_nxt;
      gray_r <= gray_nxt;
    end
  end

  // reset color of the current entry
  always_comb begin
    if (idx_r < CW'(16)) begin
      wdata = tccr_named(idx_r[3:0]);
    end else if (in_cube) begin
      wdata = {tccr_cube_level(cr_r), tccr_cube_level(cg_r), tccr_cube_level(cb_r)};
    end else if (in_gray) begin
      wdata = {gray_r, gray_r, gray_r};
    end else if (idx_r < CW'(262)) begin
      wdata = tccr_special(idx_r[2:0]);
    end else begin
      wdata = '0;
    end
  end

  assign busy  = busy_r;
  assign waddr = idx_r[$clog2(ENTRIES)-1:0];

endmodule

// File: rtl/core/tccr_resolve.sv
module tccr_resolve (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cell_valid,
  input  tccr_pkg::tccr_cell_t       cell_in,
  input  logic [tccr_pkg::RGB_W-1:0] rd_fg,
  input  logic [tccr_pkg::RGB_W-1:0] rd_bg,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_fg_red,
  output logic [7:0]                 out_fg_green,
  output logic [7:0]                 out_fg_blue,
  output logic [7:0]                 out_bg_red,
  output logic [7:0]                 out_bg_green,
  output logic [7:0]                 out_bg_blue
);

  import tccr_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0] fg_r, bg_r;
  logic [RGB_W-1:0] fg_base, bg_base, fg_dim, fg_sw, bg_sw, fg_fin;

  // pick palette read or direct rgb
  always_comb begin
    if (cell_in.fg_true) begin
      fg_base = cell_in.fg_rgb;
    end else if (cell_in.fg_black) begin
      fg_base = '0;
    end else begin
      fg_base = rd_fg;
    end
    if (cell_in.bg_true) begin
      bg_base = cell_in.bg_rgb;
    end else if (cell_in.bg_black) begin
      bg_base = '0;
    end else begin
      bg_base = rd_bg;
    end
  end

  // faint, reverse swap, then hide
  always_comb begin
    fg_dim = cell_in.faint ? ((fg_base >> 1) & 24'h7f7f7f) : fg_base;
    fg_sw  = cell_in.swap ? bg_base : fg_dim;
    bg_sw  = cell_in.swap ? fg_dim : bg_base;
    fg_fin = cell_in.hide ? bg_sw : fg_sw;
  end

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = take ? cell_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && cell_valid) begin
      fg_r <= fg_fin;
      bg_r <= bg_sw;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_fg_red   = fg_r[23:16];
  assign out_fg_green = fg_r[15:8];
  assign out_fg_blue  = fg_r[7:0];
  assign out_bg_red   = bg_r[23:16];
  assign out_bg_green = bg_r[15:8];
  assign out_bg_blue  = bg_r[7:0];

endmodule

// File: rtl/core/text_cell_color_resolver.sv
// Terminal cell color resolver. Each op 0 transfer carries one cell (fg and bg codes, each a
// direct RGB value or a palette index, plus attribute flags) and yields one transfer of
// resolved fg and bg RGB; an op 1 transfer writes one in-range palette entry and yields nothing.
// Items are taken one per cycle while in_stall is low: the palette memory is read
// at the input transfer with its two registered read ports (fg and bg), and the attribute
// logic feeds the output register. After reset the palette is loaded with the xterm
// defaults by a sweep of one entry per cycle over all PALETTE_ENTRIES entries, during which
// in_stall stays high; configuration writes are taken at any time (cfg_ready is always
// high) and should only be issued while no cell is in flight.
module text_cell_color_resolver #(
  parameter int unsigned PALETTE_ENTRIES = 262
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic                        in_fg_true,
  input  logic [tccr_pkg::RGB_W-1:0]  in_fg_value,
  input  logic                        in_bg_true,
  input  logic [tccr_pkg::RGB_W-1:0]  in_bg_value,
  input  logic                        in_bold,
  input  logic                        in_faint,
  input  logic                        in_reverse,
  input  logic                        in_blink,
  input  logic                        in_invisible,
  input  logic                        in_selected,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_fg_red,
  output logic [7:0]                  out_fg_green,
  output logic [7:0]                  out_fg_blue,
  output logic [7:0]                  out_bg_red,
  output logic [7:0]                  out_bg_green,
  output logic [7:0]                  out_bg_blue,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [tccr_pkg::DFLT_W-1:0] cfg_data
);

  import tccr_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [RGB_W-1:0] ENT_V = RGB_W'(PALETTE_ENTRIES);
  localparam logic [DFLT_W:0] ENT_D = (DFLT_W + 1)'(PALETTE_ENTRIES);

  logic [DFLT_W-1:0] def_fg_r, def_fg_nxt, def_bg_r, def_bg_nxt;
  logic              blink_hide_r, blink_hide_nxt;

  logic              init_busy;
  logic [AW-1:0]     init_addr;
  logic [RGB_W-1:0]  init_data;

  logic              accept, resolve_acc, s1_adv, take;
  logic              s1_valid_r, s1_valid_nxt;
  tccr_cell_t        s1_r, s1_nxt;

  logic              bold_hit, fg_in, bg_in, def_fg_in, def_bg_in;
  logic [AW-1:0]     fg_addr, bg_addr;
  logic              pal_we;
  logic [AW-1:0]     pal_waddr;
  logic [RGB_W-1:0]  pal_wdata;
  logic [RGB_W-1:0]  rd_fg, rd_bg;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    def_fg_nxt     = def_fg_r;
    def_bg_nxt     = def_bg_r;
    blink_hide_nxt = blink_hide_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEFAULT_FG: def_fg_nxt = cfg_data;
        CFG_DEFAULT_BG: def_bg_nxt = cfg_data;
        CFG_BLINK_HIDE: blink_hide_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_fg_r     <= DFLT_W'(256);
      def_bg_r     <= DFLT_W'(257);
      blink_hide_r <= 1'b0;
    end else begin
      def_fg_r     <= def_fg_nxt;
      def_bg_r     <= def_bg_nxt;
      blink_hide_r <= blink_hide_nxt;
    end
  end

  // palette reset sweep
  tccr_init #(
    .ENTRIES(PALETTE_ENTRIES)
  ) u_init (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (init_busy),
    .waddr (init_addr),
    .wdata (init_data)
  );

  // input handshake
  assign s1_adv      = !s1_valid_r || take;
  assign in_stall    = init_busy || !s1_adv;
  assign accept      = in_valid && !in_stall;
  assign resolve_acc = accept && (in_op == OP_RESOLVE);

  // palette addresses for the cell
  always_comb begin
    bold_hit  = in_bold && !in_faint && !in_fg_true && (in_fg_value[RGB_W-1:3] == '0);
    fg_in     = in_fg_value < ENT_V;
    bg_in     = in_bg_value < ENT_V;
    def_fg_in = {1'b0, def_fg_r} < ENT_D;
    def_bg_in = {1'b0, def_bg_r} < ENT_D;
    if (bold_hit) begin
      fg_addr = AW'({1'b1, in_fg_value[2:0]});
    end else if (fg_in) begin
      fg_addr = in_fg_value[AW-1:0];
    end else begin
      fg_addr = def_fg_r[AW-1:0];
    end
    bg_addr = bg_in ? in_bg_value[AW-1:0] : def_bg_r[AW-1:0];
  end

  // palette write: reset sweep first, then op 1 transfers
  always_comb begin
    if (init_busy) begin
      pal_we    = 1'b1;
      pal_waddr = init_addr;
      pal_wdata = init_data;
    end else begin
      pal_we    = accept && (in_op == OP_WRITE) && bg_in;
      pal_waddr = in_bg_value[AW-1:0];
      pal_wdata = in_fg_value;
    end
  end

  tccr_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (pal_waddr),
    .wdata   (pal_wdata),
    .re_a    (resolve_acc),
    .raddr_a (fg_addr),
    .rdata_a (rd_fg),
    .re_b    (resolve_acc),
    .raddr_b (bg_addr),
    .rdata_b (rd_bg)
  );

  // lookup stage register
  always_comb begin
    s1_nxt.fg_true  = in_fg_true;
    s1_nxt.fg_rgb   = in_fg_value;
    s1_nxt.fg_black = !bold_hit && !fg_in && !def_fg_in;
    s1_nxt.bg_true  = in_bg_true;
    s1_nxt.bg_rgb   = in_bg_value;
    s1_nxt.bg_black = !bg_in && !def_bg_in;
    s1_nxt.faint    = in_faint && !in_bold;
    s1_nxt.swap     = in_reverse ^ in_selected;
    s1_nxt.hide     = (in_blink && blink_hide_r) || in_invisible;
    s1_valid_nxt    = s1_adv ? resolve_acc : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // attribute logic and result register
  tccr_resolve u_resolve (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (s1_valid_r),
    .cell_in      (s1_r),
    .rd_fg        (rd_fg),
    .rd_bg        (rd_bg),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_fg_red   (out_fg_red),
    .out_fg_green (out_fg_green),
    .out_fg_blue  (out_fg_blue),
    .out_bg_red   (out_bg_red),
    .out_bg_green (out_bg_green),
    .out_bg_blue  (out_bg_blue)
  );

endmodule

// File: rtl/core/tccr_checker.sv
`include "assert_macros.svh"

module tccr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_fg_red,
  input logic [7:0] out_fg_green,
  input logic [7:0] out_fg_blue,
  input logic [7:0] out_bg_red,
  input logic [7:0] out_bg_green,
  input logic [7:0] out_bg_blue
);

  import tccr_pkg::*;

  logic        cell_xfer;
  logic [47:0] out_rgb;

  assign cell_xfer = in_valid && !in_stall && (in_op == OP_RESOLVE);
  assign out_rgb   = {out_fg_red, out_fg_green, out_fg_blue, out_bg_red, out_bg_green, out_bg_blue};

  // a stalled result keeps its valid and its colors
  `TCCR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_rgb), "stalled result changed")

  // palette load holds off input right after reset
  `TCCR_ASSERT_ALWAYS(a_init_stall, !rst_n |=> in_stall, "input open during palette load")

  // a cell passes the lookup register and reaches the output register when the output is not stalled
  `TCCR_ASSERT(a_latency, cell_xfer ##1 !out_stall |=> out_valid, "cell result missing")

  // a fresh result always comes from a cell transfer, never from a palette write
  `TCCR_ASSERT(a_no_phantom, $rose(out_valid) |-> $past(cell_xfer, 2), "result without a cell")

endmodule

bind text_cell_color_resolver tccr_checker u_tccr_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tccr_pkg::*;

  localparam int PAL_N = 262;
  localparam int PHASE_ITEMS = 110;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE = 4;
  localparam int DRAIN_LIMIT = 20000;

  // cell flags packed as {bold, faint, reverse, blink, invisible, selected}
  localparam logic [5:0] F_NONE  = 6'b000000;
  localparam logic [5:0] F_BOLD  = 6'b100000;
  localparam logic [5:0] F_FAINT = 6'b010000;
  localparam logic [5:0] F_REV   = 6'b001000;
  localparam logic [5:0] F_BLINK = 6'b000100;
  localparam logic [5:0] F_INVIS = 6'b000010;
  localparam logic [5:0] F_SEL   = 6'b000001;
  localparam logic [5:0] F_ALL   = 6'b111111;

  typedef struct packed {
    logic             op;
    logic             fg_true;
    logic [RGB_W-1:0] fg_value;
    logic             bg_true;
    logic [RGB_W-1:0] bg_value;
    logic [5:0]       flags;
  } cell_t;

  typedef struct packed {
    logic [RGB_W-1:0] fg;
    logic [RGB_W-1:0] bg;
  } color_pair_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_RESOLVE;
  logic              in_fg_true = 1'b0;
  logic [RGB_W-1:0]  in_fg_value = '0;
  logic              in_bg_true = 1'b0;
  logic [RGB_W-1:0]  in_bg_value = '0;
  logic              in_bold = 1'b0;
  logic              in_faint = 1'b0;
  logic              in_reverse = 1'b0;
  logic              in_blink = 1'b0;
  logic              in_invisible = 1'b0;
  logic              in_selected = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_fg_red, out_fg_green, out_fg_blue;
  logic [7:0]        out_bg_red, out_bg_green, out_bg_blue;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_DEFAULT_FG;
  logic [DFLT_W-1:0] cfg_data = '0;

  text_cell_color_resolver #(.PALETTE_ENTRIES(PAL_N)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_fg_true   (in_fg_true),
    .in_fg_value  (in_fg_value),
    .in_bg_true   (in_bg_true),
    .in_bg_value  (in_bg_value),
    .in_bold      (in_bold),
    .in_faint     (in_faint),
    .in_reverse   (in_reverse),
    .in_blink     (in_blink),
    .in_invisible (in_invisible),
    .in_selected  (in_selected),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_fg_red   (out_fg_red),
    .out_fg_green (out_fg_green),
    .out_fg_blue  (out_fg_blue),
    .out_bg_red   (out_bg_red),
    .out_bg_green (out_bg_green),
    .out_bg_blue  (out_bg_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow palette and registers
  logic [RGB_W-1:0]  pal [0:PAL_N-1];
  logic [DFLT_W-1:0] dflt_fg = 9'd256;
  logic [DFLT_W-1:0] dflt_bg = 9'd257;
  logic              blink_hide = 1'b0;

  cell_t       cell_q[$];
  color_pair_t color_exp_q[$];

  int  err_cnt = 0;
  bit  drain_failed = 1'b0;
  int  hold_req = 0;

  function automatic logic [7:0] cube_chan(input int x);
    return (x == 0) ? 8'd0 : 8'(55 + 40 * x);
  endfunction

  // xterm defaults: named colors, 6x6x6 cube, gray ramp, specials
  task automatic load_xterm_palette();
    logic [RGB_W-1:0] named [16] = '{
      24'h000000, 24'hcd0000, 24'h00cd00, 24'hcdcd00,
      24'h0000ee, 24'hc000c0, 24'h00cdcd, 24'he5e5e5,
      24'h7f7f7f, 24'hff0000, 24'h00ff00, 24'hffff00,
      24'h5c5cff, 24'hff00ff, 24'h00ffff, 24'hffffff};
    logic [RGB_W-1:0] extra [6] = '{
      24'hcccccc, 24'h000000, 24'h555555, 24'hcccccc, 24'h000000, 24'hcccccc};
    int k;
    logic [7:0] g;
    for (int i = 0; i < PAL_N; i++) begin
      if (i < 16) begin
        pal[i] = named[i];
      end else if (i < 232) begin
        k = i - 16;
        pal[i] = {cube_chan(k / 36), cube_chan((k / 6) % 6), cube_chan(k % 6)};
      end else if (i < 256) begin
        g = 8'(8 + 10 * (i - 232));
        pal[i] = {g, g, g};
      end else begin
        pal[i] = extra[i - 256];
      end
    end
  endtask

  // palette index or direct rgb to a color, out-of-range defaults read black
  function automatic logic [RGB_W-1:0] pick_color(input logic is_rgb,
                                                  input logic [RGB_W-1:0] code,
                                                  input logic [DFLT_W-1:0] dflt);
    if (is_rgb) return code;
    if (code < PAL_N) return pal[code];
    if (dflt < PAL_N) return pal[dflt];
    return '0;
  endfunction

  // update the shadow palette or queue the resolved colors of one cell
  task automatic apply_cell(input cell_t c);
    logic bold, faint, rev, blink, invis, sel;
    logic [RGB_W-1:0] fg, bg, tmp;
    {bold, faint, rev, blink, invis, sel} = c.flags;
    if (c.op == OP_WRITE) begin
      if (c.bg_value < PAL_N) pal[c.bg_value] = c.fg_value;
    end else begin
      fg = pick_color(c.fg_true, c.fg_value, dflt_fg);
      bg = pick_color(c.bg_true, c.bg_value, dflt_bg);
      if (bold && !faint && !c.fg_true && c.fg_value <= 7) fg = pal[c.fg_value + 8];
      if (faint && !bold) fg = (fg >> 1) & 24'h7f7f7f;
      if (rev != sel) begin
        tmp = fg;
        fg = bg;
        bg = tmp;
      end
      if (blink && blink_hide) fg = bg;
      if (invis) fg = bg;
      color_exp_q.push_back('{fg: fg, bg: bg});
    end
  endtask

  function automatic cell_t mk(input logic op, input logic ft, input int unsigned fv,
                               input logic bt, input int unsigned bv, input logic [5:0] fl);
    cell_t c;
    c.op = op;
    c.fg_true = ft;
    c.fg_value = fv[RGB_W-1:0];
    c.bg_true = bt;
    c.bg_value = bv[RGB_W-1:0];
    c.flags = fl;
    return c;
  endfunction

  // palette index spread: bold range, valid range, around the end, any value, named range
  function automatic logic [RGB_W-1:0] rand_index();
    case ($urandom_range(0, 4))
      0:       return RGB_W'($urandom_range(0, 7));
      1:       return RGB_W'($urandom_range(0, PAL_N - 1));
      2:       return RGB_W'($urandom_range(PAL_N - 2, PAL_N + 255));
      3:       return RGB_W'($urandom());
      default: return RGB_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.op = ($urandom_range(0, 6) == 0) ? OP_WRITE : OP_RESOLVE;
    c.fg_true = 1'($urandom_range(0, 1));
    c.bg_true = 1'($urandom_range(0, 1));
    c.fg_value = c.fg_true ? RGB_W'($urandom()) : rand_index();
    c.bg_value = c.bg_true ? RGB_W'($urandom()) : rand_index();
    c.flags = 6'($urandom());
    c.flags[2] = ($urandom_range(0, 3) == 0);
    c.flags[1] = ($urandom_range(0, 3) == 0);
    if (c.op == OP_WRITE) begin
      c.fg_value = RGB_W'($urandom());
      c.bg_value = ($urandom_range(0, 7) == 0) ? RGB_W'($urandom())
                                               : RGB_W'($urandom_range(0, PAL_N - 1));
    end
    return c;
  endfunction

  // random cells, some as a palette write directly followed by a read of that entry
  task automatic fill_random(input int n);
    cell_t c;
    int e;
    for (int i = 0; i < n; i++) begin
      c = rand_cell();
      if ($urandom_range(0, 7) == 0) begin
        e = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, PAL_N - 1);
        cell_q.push_back(mk(OP_WRITE, 1'b0, $urandom(), 1'b0, e, F_NONE));
        c.op = OP_RESOLVE;
        c.fg_true = 1'b0;
        c.fg_value = ($urandom_range(0, 1) && e >= 8) ? RGB_W'(e - 8) : RGB_W'(e);
        if ($urandom_range(0, 1)) begin
          c.bg_true = 1'b0;
          c.bg_value = RGB_W'(e);
        end
      end
      cell_q.push_back(c);
    end
  endtask

  // wait for every pending cell and result, then let the pipe settle
  task automatic wait_idle();
    int n = 0;
    while ((cell_q.size() != 0 || in_valid || color_exp_q.size() != 0) && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (n >= DRAIN_LIMIT) begin
      drain_failed = 1'b1;
      $display("results still outstanding after %0d cycles", n);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic set_regs(input logic [DFLT_W-1:0] fg_idx, input logic [DFLT_W-1:0] bg_idx,
                          input logic hide);
    logic [DFLT_W-1:0] vals [3];
    logic [1:0] idxs [3];
    vals = '{fg_idx, bg_idx, {{(DFLT_W - 1){1'b0}}, hide}};
    idxs = '{CFG_DEFAULT_FG, CFG_DEFAULT_BG, CFG_BLINK_HIDE};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    dflt_fg = fg_idx;
    dflt_bg = bg_idx;
    blink_hide = hide;
  endtask

  // input driver: bursts with random gaps, payload held while stalled
  cell_t drv_cell, drv_next;
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_cell(drv_cell);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cell_q.size() != 0) begin
          drv_next = cell_q.pop_front();
          drv_cell <= drv_next;
          in_valid <= 1'b1;
          in_op <= drv_next.op;
          in_fg_true <= drv_next.fg_true;
          in_fg_value <= drv_next.fg_value;
          in_bg_true <= drv_next.bg_true;
          in_bg_value <= drv_next.bg_value;
          {in_bold, in_faint, in_reverse, in_blink, in_invisible, in_selected} <= drv_next.flags;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus long hold-offs on request
  int hold_done = 0;
  int hold_left = 0;
  int seg_left = 0;
  stall_mode_t seg_mode = STALL_NONE;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = stall_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (seg_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // result checker against the oldest expected color pair
  string       chan_name [6] = '{"fg_red", "fg_green", "fg_blue", "bg_red", "bg_green", "bg_blue"};
  logic [7:0]  got [6];
  logic [7:0]  want [6];
  color_pair_t want_pair;
  string       bad_fields;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_fg_red, out_fg_green, out_fg_blue, out_bg_red, out_bg_green, out_bg_blue};
      if (color_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected result fg %02h%02h%02h bg %02h%02h%02h", $realtime,
                   got[0], got[1], got[2], got[3], got[4], got[5]);
      end else begin
        want_pair = color_exp_q.pop_front();
        want = '{want_pair.fg[23:16], want_pair.fg[15:8], want_pair.fg[7:0],
                 want_pair.bg[23:16], want_pair.bg[15:8], want_pair.bg[7:0]};
        bad_fields = "";
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i]) bad_fields = {bad_fields, " ", chan_name[i]};
        if (bad_fields != "") begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch in%s: exp fg %06h bg %06h, got fg %02h%02h%02h bg %02h%02h%02h",
                     $realtime, bad_fields, want_pair.fg, want_pair.bg,
                     got[0], got[1], got[2], got[3], got[4], got[5]);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    load_xterm_palette();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed cells under reset defaults
    cell_q.push_back(mk(OP_RESOLVE, 0, 1, 0, 0, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 0, 1, 0, 4, F_BOLD));
    cell_q.push_back(mk(OP_RESOLVE, 0, 7, 0, 0, F_BOLD));
    cell_q.push_back(mk(OP_RESOLVE, 0, 8, 0, 0, F_BOLD));
    cell_q.push_back(mk(OP_RESOLVE, 0, 3, 0, 0, F_BOLD | F_FAINT));
    cell_q.push_back(mk(OP_RESOLVE, 1, 3, 1, 24'hffffff, F_BOLD));
    cell_q.push_back(mk(OP_RESOLVE, 1, 24'hffffff, 1, 0, F_FAINT));
    cell_q.push_back(mk(OP_RESOLVE, 0, 255, 0, 232, F_REV));
    cell_q.push_back(mk(OP_RESOLVE, 0, PAL_N - 1, 0, 16, F_SEL));
    cell_q.push_back(mk(OP_RESOLVE, 0, 100, 0, 200, F_REV | F_SEL));
    cell_q.push_back(mk(OP_RESOLVE, 0, PAL_N, 0, 24'hffffff, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 1, 24'h123456, 1, 24'hfedcba, F_INVIS));
    cell_q.push_back(mk(OP_RESOLVE, 0, 9, 0, 1, F_BLINK | F_REV));
    cell_q.push_back(mk(OP_WRITE, 0, 24'habcdef, 0, 0, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 0, 0, 0, 0, F_NONE));
    cell_q.push_back(mk(OP_WRITE, 1, 24'h010203, 1, PAL_N - 1, F_ALL));
    // writes past the palette end are dropped
    cell_q.push_back(mk(OP_WRITE, 0, 24'h777777, 0, PAL_N, F_NONE));
    cell_q.push_back(mk(OP_WRITE, 0, 24'h888888, 0, 24'hffffff, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 0, PAL_N - 1, 0, PAL_N, F_NONE));
    // default fg entry rewritten, then used by an out-of-range index
    cell_q.push_back(mk(OP_WRITE, 0, 24'h00ff80, 0, 256, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 0, 300, 1, 24'h000000, F_FAINT));
    // bright entry rewritten right before a bold read
    cell_q.push_back(mk(OP_WRITE, 0, 24'h102030, 0, 8, F_NONE));
    cell_q.push_back(mk(OP_RESOLVE, 0, 0, 0, 8, F_BOLD));
    cell_q.push_back(mk(OP_RESOLVE, 0, 5, 0, 7, F_ALL));
    fill_random(PHASE_ITEMS);
    wait_idle();

    // extreme defaults, blink hidden
    set_regs(9'd0, 9'(PAL_N - 1), 1'b1);
    fill_random(PHASE_ITEMS);
    wait_idle();

    // long receiver hold-off while cells keep coming
    set_regs(9'(PAL_N - 1), 9'd0, 1'b0);
    fill_random(PHASE_ITEMS);
    hold_req <= hold_req + 1;
    wait_idle();

    // defaults past the palette end read black
    set_regs(9'd511, 9'(PAL_N), 1'b1);
    fill_random(PHASE_ITEMS);
    wait_idle();

    set_regs(9'($urandom_range(0, PAL_N - 1)), 9'($urandom_range(0, 511)),
             1'($urandom_range(0, 1)));
    fill_random(PHASE_ITEMS);
    hold_req <= hold_req + 1;
    wait_idle();

    // back to reset values
    set_regs(9'd256, 9'd257, 1'b0);
    fill_random(PHASE_ITEMS);
    wait_idle();
    repeat (10) @(posedge clk);

    if (err_cnt == 0 && !drain_failed && color_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: text_cell_color_resolver.f
+incdir+rtl/core
rtl/core/tccr_pkg.sv
rtl/core/tccr_ram.sv
rtl/core/tccr_init.sv
rtl/core/tccr_resolve.sv
rtl/core/text_cell_color_resolver.sv
rtl/core/tccr_checker.sv
tb/tb.sv
